// File: rtl/prpseg_pkg.sv
// shared types and constants of the prp dma segmenter
package prpseg_pkg;

   // length fields are wide enough for 65536 blocks of up to 4 KiB
   localparam int unsigned LEN_W       = 29;
   // list entry count, enough for 4095 prps
   localparam int unsigned CNT_W       = 12;
   localparam int unsigned BYTES_W     = 22;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic       REQ_COMMAND = 1'b0;
   localparam logic       REQ_ENTRY   = 1'b1;

   localparam logic [7:0] OPC_WRITE  = 8'h01;
   localparam logic [7:0] OPC_READ   = 8'h02;
   localparam logic [7:0] OPC_APPEND = 8'h7d;

   typedef enum logic [1:0] {
      KIND_FETCH  = 2'd0,
      KIND_DESC   = 2'd1,
      KIND_REJECT = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_REJECT = 3'd1,
      OP_SINGLE = 3'd2,
      OP_PAIR   = 3'd3,
      OP_LIST   = 3'd4,
      OP_ENTRY  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'b01,
      PH_LIST = 2'b10
   } phase_type;

   // one classified work item passed from front to back
   typedef struct packed {
      op_type             op;
      logic               dir_write;
      logic [63:0]        cursor;
      logic [63:0]        host_a;
      logic [63:0]        host_b;
      logic [LEN_W-1:0]   bytes_a;
      logic [LEN_W-1:0]   bytes_b;
      logic [CNT_W-1:0]   count;
   } entry_type;

endpackage

// File: rtl/prpseg_req_if.sv
// request channel: commands and prp list entries
interface prpseg_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  opcode;
   logic [39:0] start_block;
   logic [15:0] block_count_minus_one;
   logic [63:0] first_pointer;
   logic [63:0] second_pointer;
   logic [63:0] list_entry;

   modport source (
      output valid, req_type, opcode, start_block, block_count_minus_one,
             first_pointer, second_pointer, list_entry,
      input  ready
   );
   modport sink (
      input  valid, req_type, opcode, start_block, block_count_minus_one,
             first_pointer, second_pointer, list_entry,
      output ready
   );
endinterface

// File: rtl/prpseg_rsp_if.sv
// response channel: fetch requests, dma descriptors and status results
interface prpseg_rsp_if;
   import prpseg_pkg::*;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [63:0] source_address;
   logic [63:0] dest_address;
   logic [21:0] byte_count;
   logic        is_last;

   modport source (
      output valid, kind, source_address, dest_address, byte_count, is_last,
      input  ready
   );
   modport sink (
      input  valid, kind, source_address, dest_address, byte_count, is_last,
      output ready
   );
endinterface

// File: rtl/prpseg_front.sv
// front end: takes requests, sizes the command and classifies it
module prpseg_front #(
   parameter int unsigned PAGE_BYTES  = 4096,
   parameter int unsigned BLOCK_SHIFT = 9,
   parameter int unsigned MAX_PRPS    = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [63:0]           csr_wr_data,
   prpseg_req_if.sink            req,
   input  logic                  queue_full,
   output logic                  push,
   output prpseg_pkg::entry_type push_entry
);
   import prpseg_pkg::*;

   localparam int unsigned OFFSET_BITS = $clog2(PAGE_BYTES);

   logic [63:0]      storage_base_ff;
   logic [63:0]      storage_base_in;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] first;
   logic [LEN_W-1:0] rem;
   logic [LEN_W-1:0] extra_pages;
   logic             fits_one;
   logic             too_long;
   logic             two_pages;
   logic             pair_merge;
   logic             is_rw;
   logic             dir_write;
   logic [63:0]      second_page;
   logic [63:0]      entry_page;
   logic [63:0]      cursor;
   entry_type        e;

   assign storage_base_in = csr_wr_en ? csr_wr_data : storage_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         storage_base_ff <= '0;
      end else begin
         storage_base_ff <= storage_base_in;
      end
   end

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   // transfer sizing
   assign len   = LEN_W'({1'b0, req.block_count_minus_one} + 17'd1) << BLOCK_SHIFT;
   assign first = LEN_W'(PAGE_BYTES) - LEN_W'(req.first_pointer[OFFSET_BITS-1:0]);
   assign rem   = len - first;
   assign extra_pages = (rem + LEN_W'(PAGE_BYTES - 1)) >> OFFSET_BITS;
   assign fits_one    = len <= first;
   assign too_long    = !fits_one && (extra_pages >= LEN_W'(MAX_PRPS));
   assign two_pages   = extra_pages == LEN_W'(1);

   assign second_page = {req.second_pointer[63:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
   assign entry_page  = {req.list_entry[63:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
   assign pair_merge  = second_page == (req.first_pointer + 64'(PAGE_BYTES));
   assign cursor      = storage_base_ff + (64'(req.start_block) << BLOCK_SHIFT);

   always_comb begin
      unique case (req.opcode) inside
         OPC_WRITE, OPC_APPEND: begin
            is_rw     = 1'b1;
            dir_write = 1'b1;
         end
         OPC_READ: begin
            is_rw     = 1'b1;
            dir_write = 1'b0;
         end
         default: begin
            is_rw     = 1'b0;
            dir_write = 1'b0;
         end
      endcase
   end

   always_comb begin
      e           = '0;
      e.op        = OP_NONE;
      e.dir_write = dir_write;
      e.cursor    = cursor;
      e.host_a    = req.first_pointer;
      e.host_b    = req.second_pointer;
      e.bytes_a   = first;
      e.bytes_b   = rem;
      e.count     = extra_pages[CNT_W-1:0];
      if (req.req_type == REQ_ENTRY) begin
         e.op     = OP_ENTRY;
         e.host_a = entry_page;
      end else if (!is_rw) begin
         e.op = OP_NONE;
      end else if (fits_one) begin
         e.op      = OP_SINGLE;
         e.bytes_a = len;
      end else if (too_long) begin
         e.op = OP_REJECT;
      end else if (two_pages) begin
         if (pair_merge) begin
            e.op      = OP_SINGLE;
            e.bytes_a = len;
         end else begin
            e.op     = OP_PAIR;
            e.host_b = second_page;
         end
      end else begin
         e.op = OP_LIST;
      end
   end

   assign push_entry = e;

endmodule

// File: rtl/prpseg_queue.sv
// small register queue between front and back
module prpseg_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  prpseg_pkg::entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output prpseg_pkg::entry_type head,
   output logic                  head_valid
);
   import prpseg_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LVL_W = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [LVL_W-1:0] level_ff;
   logic [LVL_W-1:0] level_in;

   assign full       = level_ff == LVL_W'(DEPTH);
   assign head_valid = level_ff != '0;
   assign head       = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/prpseg_back.sv
// back end: walks the prp list, merges pages and issues results
module prpseg_back #(
   parameter int unsigned PAGE_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  prpseg_pkg::entry_type head,
   input  logic                  head_valid,
   output logic                  pop,
   prpseg_rsp_if.source          rsp
);
   import prpseg_pkg::*;

   localparam logic [63:0]      PAGE_STEP = 64'(PAGE_BYTES);
   localparam logic [LEN_W-1:0] PAGE_LEN  = LEN_W'(PAGE_BYTES);

   phase_type          phase_ff, phase_in;
   logic               second_ff, second_in;
   logic               dir_ff, dir_in;
   logic [63:0]        cursor_ff, cursor_in;
   logic [63:0]        seg_start_ff, seg_start_in;
   logic [LEN_W-1:0]   seg_bytes_ff, seg_bytes_in;
   logic [63:0]        prev_ff, prev_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic [CNT_W-1:0]   left_ff, left_in;

   logic               valid_ff, valid_in;
   kind_type           kind_ff;
   logic [63:0]        src_ff;
   logic [63:0]        dst_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic               last_ff;

   logic               out_free;
   logic               step;
   logic               merge;
   logic               closing_entry;
   logic [LEN_W-1:0]   piece;
   logic               emit;
   kind_type           emit_kind;
   logic               use_head;
   logic [63:0]        desc_host;
   logic [LEN_W-1:0]   desc_bytes;
   logic               desc_last;
   logic [63:0]        cur;
   logic               cur_dir;
   logic [63:0]        cursor_next;
   logic [63:0]        emit_src;
   logic [63:0]        emit_dst;
   logic [BYTES_W-1:0] emit_bytes;

   assign out_free      = !valid_ff || rsp.ready;
   assign step          = head_valid && out_free;
   assign merge         = head.host_a == (prev_ff + PAGE_STEP);
   assign closing_entry = left_ff == CNT_W'(1);
   assign piece         = (remain_ff < PAGE_LEN) ? remain_ff : PAGE_LEN;

   assign cur         = use_head ? head.cursor : cursor_ff;
   assign cur_dir     = use_head ? head.dir_write : dir_ff;
   assign cursor_next = cur + 64'(desc_bytes);

   always_comb begin
      pop          = 1'b0;
      emit         = 1'b0;
      emit_kind    = KIND_DESC;
      use_head     = 1'b0;
      desc_host    = head.host_a;
      desc_bytes   = head.bytes_a;
      desc_last    = 1'b0;
      phase_in     = phase_ff;
      second_in    = second_ff;
      dir_in       = dir_ff;
      cursor_in    = cursor_ff;
      seg_start_in = seg_start_ff;
      seg_bytes_in = seg_bytes_ff;
      prev_in      = prev_ff;
      remain_in    = remain_ff;
      left_in      = left_ff;
      if (step) begin
         unique case (head.op)
            OP_NONE, OP_REJECT: begin
               emit      = 1'b1;
               emit_kind = (head.op == OP_NONE) ? KIND_NONE : KIND_REJECT;
               desc_last = 1'b1;
               phase_in  = PH_IDLE;
               pop       = 1'b1;
            end
            OP_SINGLE: begin
               emit      = 1'b1;
               use_head  = 1'b1;
               desc_last = 1'b1;
               dir_in    = head.dir_write;
               cursor_in = cursor_next;
               phase_in  = PH_IDLE;
               pop       = 1'b1;
            end
            OP_PAIR: begin
               emit     = 1'b1;
               phase_in = PH_IDLE;
               if (!second_ff) begin
                  use_head  = 1'b1;
                  dir_in    = head.dir_write;
                  cursor_in = cursor_next;
                  second_in = 1'b1;
               end else begin
                  desc_host  = head.host_b;
                  desc_bytes = head.bytes_b;
                  desc_last  = 1'b1;
                  cursor_in  = cursor_next;
                  second_in  = 1'b0;
                  pop        = 1'b1;
               end
            end
            OP_LIST: begin
               emit         = 1'b1;
               emit_kind    = KIND_FETCH;
               dir_in       = head.dir_write;
               cursor_in    = head.cursor;
               seg_start_in = head.host_a;
               seg_bytes_in = head.bytes_a;
               prev_in      = head.host_a;
               remain_in    = head.bytes_b;
               left_in      = head.count;
               phase_in     = PH_LIST;
               pop          = 1'b1;
            end
            OP_ENTRY: begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     pop = 1'b1;
                  end
                  PH_LIST: begin
                     desc_host  = seg_start_ff;
                     desc_bytes = seg_bytes_ff;
                     if (!second_ff) begin
                        if (!merge) begin
                           emit         = 1'b1;
                           cursor_in    = cursor_next;
                           seg_start_in = head.host_a;
                           seg_bytes_in = piece;
                        end else begin
                           seg_bytes_in = seg_bytes_ff + piece;
                        end
                        prev_in   = head.host_a;
                        remain_in = remain_ff - piece;
                        left_in   = left_ff - CNT_W'(1);
                        if (closing_entry) begin
                           second_in = 1'b1;
                        end else begin
                           pop = 1'b1;
                        end
                     end else begin
                        emit         = 1'b1;
                        desc_last    = 1'b1;
                        cursor_in    = cursor_next;
                        phase_in     = PH_IDLE;
                        remain_in    = '0;
                        seg_bytes_in = '0;
                        second_in    = 1'b0;
                        pop          = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     pop      = 1'b1;
                  end
               endcase
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      emit_src   = '0;
      emit_dst   = '0;
      emit_bytes = '0;
      case (emit_kind)
         KIND_DESC: begin
            emit_src   = cur_dir ? desc_host : cur;
            emit_dst   = cur_dir ? cur : desc_host;
            emit_bytes = desc_bytes[BYTES_W-1:0];
         end
         KIND_FETCH: begin
            emit_src   = head.host_b;
            emit_bytes = BYTES_W'({head.count, 3'b000});
         end
         default: begin
            emit_bytes = '0;
         end
      endcase
   end

   assign valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         second_ff    <= 1'b0;
         valid_ff     <= 1'b0;
         dir_ff       <= 1'b0;
         cursor_ff    <= '0;
         seg_start_ff <= '0;
         seg_bytes_ff <= '0;
         prev_ff      <= '0;
         remain_ff    <= '0;
         left_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         second_ff    <= second_in;
         valid_ff     <= valid_in;
         dir_ff       <= dir_in;
         cursor_ff    <= cursor_in;
         seg_start_ff <= seg_start_in;
         seg_bytes_ff <= seg_bytes_in;
         prev_ff      <= prev_in;
         remain_ff    <= remain_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= emit_kind;
         src_ff   <= emit_src;
         dst_ff   <= emit_dst;
         bytes_ff <= emit_bytes;
         last_ff  <= desc_last;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.source_address = src_ff;
   assign rsp.dest_address   = dst_ff;
   assign rsp.byte_count     = bytes_ff;
   assign rsp.is_last        = last_ff;

endmodule

// File: rtl/prp_dma_segmenter.sv
// top level of the prp dma segmenter
//
// usage
// - req_chan carries commands (req_type 0) and prp list entries (req_type 1);
//   a transfer happens at a clock edge with valid and ready both high
// - rsp_chan returns list fetch requests, dma descriptors, reject and
//   no-transfer results in command order
// - csr_wr_en/csr_wr_data load the storage base; write it only while idle
// - a request passes through the queue registers and then the output register
// - requests enter a four-entry queue, one per cycle while it is not full; the
//   back end retires most requests in one pass, but a two-page command that
//   does not merge and the list entry that closes a walk take a second pass,
//   and its pace is set by the single descriptor output port
// - list walk: after a fetch request the host streams the list entries
//   back on req_chan, one per transfer
// - reset clears the queue, the walk state, the output register and the
//   storage base
// - when rsp_chan stalls the result is held in the output register, the
//   back end stops, the queue fills and then req_chan ready drops
module prp_dma_segmenter #(
   parameter int unsigned PAGE_BYTES  = 4096,
   parameter int unsigned BLOCK_SHIFT = 9,
   parameter int unsigned MAX_PRPS    = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   prpseg_req_if.sink  req_chan,
   prpseg_rsp_if.source rsp_chan
);
   import prpseg_pkg::*;

   // front to queue
   logic      q_push;
   entry_type q_push_entry;
   logic      q_full;
   // queue to back
   logic      q_pop;
   entry_type q_head;
   logic      q_head_valid;

   // classifies each request and samples the storage base
   prpseg_front #(
      .PAGE_BYTES  (PAGE_BYTES),
      .BLOCK_SHIFT (BLOCK_SHIFT),
      .MAX_PRPS    (MAX_PRPS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_chan),
      .queue_full  (q_full),
      .push        (q_push),
      .push_entry  (q_push_entry)
   );

   // decouples request acceptance from result delivery
   prpseg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid)
   );

   // list walk, page merging and the registered result port
   prpseg_back #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (q_head_valid),
      .pop        (q_pop),
      .rsp        (rsp_chan)
   );

   // the back end only retires work that is in the queue
   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("pop from empty queue");

   // status results close a command and move nothing
   a_status_result: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.kind == KIND_NONE || rsp_chan.kind == KIND_REJECT)
      |-> rsp_chan.is_last && rsp_chan.byte_count == '0 && rsp_chan.source_address == '0)
      else $error("status result with payload");

   // a list fetch is never the last result of its command and carries no destination
   a_fetch_open: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == KIND_FETCH
      |-> !rsp_chan.is_last && rsp_chan.dest_address == '0)
      else $error("list fetch marked last");

endmodule
